// File: rtl/rope_pkg.sv
// Shared types and fixed-point constants for the rotary position embedding pair unit.
package rope_pkg;

  localparam int MUL_W = 32;
  localparam int EXP_FB = 32;
  localparam int TRIG_FB = 30;
  localparam int EXP_TERMS = 12;
  localparam int TRIG_TERMS = 8;
  localparam int DIV_STAGES = 12;
  localparam int DIV_STEP = 4;
  localparam int DIV_W = 48;

  localparam logic [31:0] LN2_Q32 = 32'hB172_17F8;
  localparam logic [31:0] INV_TWO_PI_Q32 = 32'h28BE_60DC;
  localparam logic [30:0] HALF_PI_Q30 = 31'h6487_ED51;

  typedef enum logic [0:0] {
    REG_HEAD_SIZE = 1'b0,
    REG_LOG2_BASE = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [15:0]        pos;
  } item_t;

  typedef struct packed {
    logic [DIV_W-1:0] num;
    logic [8:0]       rem;
    logic [DIV_W-1:0] quo;
  } div_t;

  typedef struct packed {
    logic [31:0] q;
    logic        big;
    logic [5:0]  nsh;
  } exp_side_t;

  typedef struct packed {
    quad_t       quad;
    logic [30:0] ang;
    logic [31:0] ang_sq;
  } trig_side_t;

endpackage

// File: rtl/rotary_position_embedding_pair_unit.sv
// Rotary position embedding of one Q4.11 element pair: a fully pipelined datapath that
// takes one pair per clock unless the output stalls. It is a chain of arithmetic stages: a
// 12-stage exponent divider (4 quotient bits a stage), a 12-term exp2 series and an 8-term
// sine/cosine series, each term three stages long (product, reciprocal multiply, correction).
// The whole pipeline advances together; it holds while a finished result waits on
// m_axis_tready, so a new request is taken whenever the output register is empty or is being
// read. Configuration writes take effect at once and belong only to an idle pipeline.
module rotary_position_embedding_pair_unit #(
  parameter int MAX_POSITIONS = 65536,
  parameter int MAX_PAIRS = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // first_value[15:0], second_value[31:16], position[47:32], pair_index[54:48], zero[55]
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // first_rotated[15:0], second_rotated[31:16]
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import rope_pkg::*;

  localparam int ST_EXP0 = DIV_STAGES + 1;
  localparam int EXP_LEN = 3 * EXP_TERMS;
  localparam int ST_F = ST_EXP0 + EXP_LEN + 1;
  localparam int ST_A = ST_F + 1;
  localparam int ST_T1 = ST_A + 1;
  localparam int ST_T2 = ST_T1 + 1;
  localparam int ST_A1 = ST_T2 + 1;
  localparam int ST_A2 = ST_A1 + 1;
  localparam int TRIG_LEN = 3 * TRIG_TERMS;
  localparam int ST_SF = ST_A2 + TRIG_LEN + 1;
  localparam int ST_P = ST_SF + 1;
  localparam int NST = ST_P + 2;

  logic [8:0]  head_size;
  logic [23:0] log2_base;
  logic [8:0]  dsz;
  logic        en;

  logic [NST-1:0] vld;
  item_t          sd [ST_SF+1];

  logic [15:0] pos_c;
  logic [6:0]  idx_c;
  logic [31:0] prod_p;

  div_t dv [DIV_STAGES+1];
  div_t dv_next [DIV_STAGES];

  logic [63:0] prod_ln;
  exp_side_t   hq [EXP_LEN+1];
  logic [EXP_FB:0] er [EXP_TERMS+1];

  logic [32:0] f;
  logic [48:0] am;
  logic [31:0] ph;
  logic [31:0] pl;
  logic [63:0] plx;
  logic [31:0] turns;
  logic [60:0] angx;
  logic [30:0] aa;
  quad_t       quad_a1;
  logic [61:0] sqx;
  trig_side_t  tq [TRIG_LEN+1];
  logic [TRIG_FB:0] sr [TRIG_TERMS+1];
  logic [TRIG_FB:0] cr [TRIG_TERMS+1];

  logic [61:0] sprodx;
  logic [30:0] sq_f;
  logic [30:0] cq_f;
  quad_t       quad_f;
  logic signed [31:0] sn;
  logic signed [31:0] cs;
  logic signed [47:0] p_xc;
  logic signed [47:0] p_ys;
  logic signed [47:0] p_xs;
  logic signed [47:0] p_yc;
  logic [15:0] out_first;
  logic [15:0] out_second;

  function automatic logic [15:0] round_sat(logic signed [48:0] s);
    logic signed [48:0] b;
    logic signed [18:0] r;
    b = s + 49'sd536870912;
    r = b[48:30];
    if (r > 19'sd32767) begin
      return 16'h7FFF;
    end else if (r < -19'sd32768) begin
      return 16'h8000;
    end
    return r[15:0];
  endfunction

  assign en = !vld[NST-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[NST-1];
  assign m_axis_tdata = {out_second, out_first};
  assign cfg_ready = 1'b1;
  assign dsz = (head_size < 9'd2) ? 9'd2 : head_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_size <= 9'd128;
      log2_base <= 24'd870824;
    end else if (cfg_valid) begin
      if (cfg_index == REG_HEAD_SIZE) begin
        head_size <= cfg_data[8:0];
      end else if (cfg_index == REG_LOG2_BASE) begin
        log2_base <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], s_axis_tvalid};
    end
  end

  // clamp and form log2_base * 2i
  always_comb begin
    pos_c = (32'(s_axis_tdata[47:32]) >= 32'(MAX_POSITIONS)) ?
            16'(MAX_POSITIONS - 1) : s_axis_tdata[47:32];
    idx_c = (32'(s_axis_tdata[54:48]) >= 32'(MAX_PAIRS)) ?
            7'(MAX_PAIRS - 1) : s_axis_tdata[54:48];
    prod_p = log2_base * {idx_c, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= '{x: s_axis_tdata[15:0], y: s_axis_tdata[31:16], pos: pos_c};
      for (int i = 1; i <= ST_SF; i++) begin
        sd[i] <= sd[i-1];
      end
    end
  end

  // exponent divider: DIV_STEP quotient bits a stage
  always_comb begin
    logic [9:0]       t;
    logic [8:0]       r;
    logic [DIV_W-1:0] nm;
    logic [DIV_W-1:0] qo;
    for (int i = 0; i < DIV_STAGES; i++) begin
      r = dv[i].rem;
      nm = dv[i].num;
      qo = dv[i].quo;
      for (int j = 0; j < DIV_STEP; j++) begin
        t = {r, nm[DIV_W-1]};
        if (t >= {1'b0, dsz}) begin
          r = 9'(t - {1'b0, dsz});
          qo = {qo[DIV_W-2:0], 1'b1};
        end else begin
          r = t[8:0];
          qo = {qo[DIV_W-2:0], 1'b0};
        end
        nm = {nm[DIV_W-2:0], 1'b0};
      end
      dv_next[i].num = nm;
      dv_next[i].rem = r;
      dv_next[i].quo = qo;
    end
  end

  assign prod_ln = dv[DIV_STAGES].quo[31:0] * LN2_Q32;

  always_ff @(posedge clk) begin
    if (en) begin
      dv[0].num <= {prod_p, 16'b0};
      dv[0].rem <= '0;
      dv[0].quo <= '0;
      for (int i = 1; i <= DIV_STAGES; i++) begin
        dv[i] <= dv_next[i-1];
      end
      hq[0].q <= prod_ln[63:32];
      hq[0].big <= dv[DIV_STAGES].quo[47:32] >= 16'd63;
      hq[0].nsh <= dv[DIV_STAGES].quo[37:32];
      for (int i = 1; i <= EXP_LEN; i++) begin
        hq[i] <= hq[i-1];
      end
    end
  end

  assign er[0] = {1'b1, {EXP_FB{1'b0}}};

  for (genvar j = 0; j < EXP_TERMS; j++) begin : g_exp
    rope_horner_step #(
      .K  (EXP_TERMS - j),
      .FB (EXP_FB)
    ) u_step (
      .clk     (clk),
      .en      (en),
      .mul     (hq[3*j].q),
      .acc_in  (er[j]),
      .acc_out (er[j+1])
    );
  end

  // position times inverse frequency, then to turns
  assign plx = am[31:0] * INV_TWO_PI_Q32;
  assign angx = turns[29:0] * HALF_PI_Q30;
  assign sqx = aa * aa;

  always_ff @(posedge clk) begin
    if (en) begin
      f <= hq[EXP_LEN].big ? '0 : er[EXP_TERMS] >> hq[EXP_LEN].nsh;
      am <= sd[ST_F].pos * f;
      ph <= 32'(am[48:32] * INV_TWO_PI_Q32);
      pl <= plx[63:32];
      turns <= ph + pl;
      aa <= angx[60:30];
      quad_a1 <= quad_t'(turns[31:30]);
      tq[0].quad <= quad_a1;
      tq[0].ang <= aa;
      tq[0].ang_sq <= sqx[61:30];
      for (int i = 1; i <= TRIG_LEN; i++) begin
        tq[i] <= tq[i-1];
      end
    end
  end

  assign sr[0] = {1'b1, {TRIG_FB{1'b0}}};
  assign cr[0] = {1'b1, {TRIG_FB{1'b0}}};

  for (genvar j = 0; j < TRIG_TERMS; j++) begin : g_trig
    rope_horner_step #(
      .K  (2 * (TRIG_TERMS - j) * (2 * (TRIG_TERMS - j) + 1)),
      .FB (TRIG_FB)
    ) u_sin (
      .clk     (clk),
      .en      (en),
      .mul     (tq[3*j].ang_sq),
      .acc_in  (sr[j]),
      .acc_out (sr[j+1])
    );
    rope_horner_step #(
      .K  ((2 * (TRIG_TERMS - j) - 1) * 2 * (TRIG_TERMS - j)),
      .FB (TRIG_FB)
    ) u_cos (
      .clk     (clk),
      .en      (en),
      .mul     (tq[3*j].ang_sq),
      .acc_in  (cr[j]),
      .acc_out (cr[j+1])
    );
  end

  assign sprodx = tq[TRIG_LEN].ang * sr[TRIG_TERMS];

  // map the quarter-turn values to signed sine and cosine
  always_comb begin
    case (quad_f)
      QUAD_0: begin
        sn = $signed({1'b0, sq_f});
        cs = $signed({1'b0, cq_f});
      end
      QUAD_1: begin
        sn = $signed({1'b0, cq_f});
        cs = -$signed({1'b0, sq_f});
      end
      QUAD_2: begin
        sn = -$signed({1'b0, sq_f});
        cs = -$signed({1'b0, cq_f});
      end
      default: begin
        sn = -$signed({1'b0, cq_f});
        cs = $signed({1'b0, sq_f});
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_f <= (sprodx[61:30] > 32'h4000_0000) ? 31'h4000_0000 : sprodx[60:30];
      cq_f <= cr[TRIG_TERMS];
      quad_f <= tq[TRIG_LEN].quad;
      p_xc <= sd[ST_SF].x * cs;
      p_ys <= sd[ST_SF].y * sn;
      p_xs <= sd[ST_SF].x * sn;
      p_yc <= sd[ST_SF].y * cs;
      out_first <= round_sat({p_xc[47], p_xc} - {p_ys[47], p_ys});
      out_second <= round_sat({p_xs[47], p_xs} + {p_yc[47], p_yc});
    end
  end

endmodule

// File: rtl/rope_horner_step.sv
// One Horner term acc = 1 - mul*acc/K over three register stages.
module rope_horner_step #(
  parameter int unsigned K = 1,
  parameter int FB = 32
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [rope_pkg::MUL_W-1:0] mul,
  input  logic [FB:0]                acc_in,
  output logic [FB:0]                acc_out
);
  import rope_pkg::*;

  localparam int L = $clog2(K + 1) - 1;
  localparam bit POW2 = (K & (K - 1)) == 0;
  localparam logic [63:0] MFULL = (64'd1 << (32 + L)) / K;
  localparam logic [31:0] M = MFULL[31:0];
  localparam logic [FB:0] ONE = {1'b1, {FB{1'b0}}};

  logic [MUL_W+FB:0] prod;
  logic [31:0]       p1;
  logic [31:0]       p2;
  logic [63:0]       pm;
  logic [31:0]       qe;
  logic [40:0]       rem;
  logic [31:0]       term;

  assign prod = mul * acc_in;

  always_comb begin
    if (POW2) begin
      qe = p2 >> L;
    end else begin
      qe = 32'(pm >> (32 + L));
    end
    rem = 41'(p2) - 41'(qe) * 41'(K);
    // reciprocal estimate is at most one low
    term = (!POW2 && rem >= 41'(K)) ? qe + 32'd1 : qe;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1 <= prod[FB+31:FB];
      p2 <= p1;
      pm <= p1 * M;
      acc_out <= (33'(term) > 33'(ONE)) ? '0 : ONE - (FB+1)'(term);
    end
  end

endmodule

// File: tb/rotary_position_embedding_pair_unit_tb.sv
// Self-checking testbench for the rotary position embedding pair unit.
module rotary_position_embedding_pair_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rope_pkg::*;

  localparam int PIPE_DRAIN = 100;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [15:0]        pos;
    logic [6:0]         idx;
  } pair_req_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [0:0]  cfg_index;
  logic [23:0] cfg_data;

  pair_req_t   pending_reqs[$];
  logic [31:0] rotated_expected[$];
  logic [8:0]  head_size_cfg;
  logic [23:0] log2_base_cfg;
  int          mismatches;
  int          pairs_sent;
  int          pairs_checked;
  int          src_idle;
  int          sink_idle;
  bit          quiet;
  bit          req_taken;

  rotary_position_embedding_pair_unit uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Q4.41 sum to Q4.11, round half up, saturate
  function automatic logic [15:0] round_q411(longint sum);
    longint unsigned shifted;
    longint r;
    shifted = longint'(sum + (64'sd1 <<< 29) + (64'sd1 <<< 47)) >> 30;
    r = longint'(shifted) - (64'sd1 <<< 17);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic logic [31:0] rotate_pair(pair_req_t p, logic [8:0] hs, logic [23:0] lb);
    longint unsigned d, e, n, frac, q, r, term, f, prod, turns, u, ang, ang2, s, c, ts, tc;
    longint signed sn, cs, xs, ys;
    logic [15:0] fr, sr;
    d = (hs < 2) ? 2 : hs;
    e = (64'(lb) * 2 * 64'(p.idx) * 65536) / d;
    n = e >> 32;
    frac = e & 64'hFFFF_FFFF;
    q = (frac * 64'(LN2_Q32)) >> 32;
    r = 64'd1 << 32;
    for (int k = 12; k >= 1; k--) begin
      term = (q * r) / (64'(k) << 32);
      r = (term > (64'd1 << 32)) ? 0 : (64'd1 << 32) - term;
    end
    f = (n >= 63) ? 0 : (r >> n);
    prod = 64'(p.pos) * f;
    turns = ((prod >> 32) * 64'(INV_TWO_PI_Q32)
            + (((prod & 64'hFFFF_FFFF) * 64'(INV_TWO_PI_Q32)) >> 32)) & 64'hFFFF_FFFF;
    u = turns & ((64'd1 << 30) - 1);
    ang = (u * 64'(HALF_PI_Q30)) >> 30;
    ang2 = (ang * ang) >> 30;
    s = 64'd1 << 30;
    c = 64'd1 << 30;
    for (int k = 8; k >= 1; k--) begin
      ts = (ang2 * s) / (64'((2 * k) * (2 * k + 1)) << 30);
      tc = (ang2 * c) / (64'((2 * k - 1) * (2 * k)) << 30);
      s = (ts > (64'd1 << 30)) ? 0 : (64'd1 << 30) - ts;
      c = (tc > (64'd1 << 30)) ? 0 : (64'd1 << 30) - tc;
    end
    s = (ang * s) >> 30;
    if (s > (64'd1 << 30)) s = 64'd1 << 30;
    case (quad_t'(turns[31:30]))
      QUAD_0: begin sn = s;  cs = c;  end
      QUAD_1: begin sn = c;  cs = -s; end
      QUAD_2: begin sn = -s; cs = -c; end
      default: begin sn = -c; cs = s; end
    endcase
    xs = p.x;
    ys = p.y;
    fr = round_q411(xs * cs - ys * sn);
    sr = round_q411(xs * sn + ys * cs);
    return {sr, fr};
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s at %0t: got %0d expected %0d", what, $time,
             $signed(got), $signed(want));
    mismatches++;
  endtask

  // request source: hold a presented request until taken, idle only between requests
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !req_taken) begin
      s_axis_tvalid <= 1'b1;
    end else if (src_idle > 0) begin
      src_idle <= src_idle - 1;
      s_axis_tvalid <= 1'b0;
    end else if (pending_reqs.size() > 0 && !quiet && $urandom_range(0, 5) == 0) begin
      src_idle <= $urandom_range(0, 2);
      s_axis_tvalid <= 1'b0;
    end else if (pending_reqs.size() > 0) begin
      s_axis_tvalid <= 1'b1;
      s_axis_tdata <= {1'b0, pending_reqs[0].idx, pending_reqs[0].pos,
                       pending_reqs[0].y, pending_reqs[0].x};
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // result sink stalls
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (sink_idle > 0) begin
      sink_idle <= sink_idle - 1;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      sink_idle <= $urandom_range(0, 2);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    req_taken <= !rst && s_axis_tvalid && s_axis_tready;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_reg_t'(cfg_index) == REG_HEAD_SIZE) head_size_cfg <= cfg_data[8:0];
        else log2_base_cfg <= cfg_data;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        rotated_expected.push_back(rotate_pair(pending_reqs[0], head_size_cfg, log2_base_cfg));
        void'(pending_reqs.pop_front());
        pairs_sent++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (rotated_expected.size() == 0) begin
          $display("unexpected result at %0t: %h", $time, m_axis_tdata);
          mismatches++;
        end else begin
          if (m_axis_tdata[15:0] !== rotated_expected[0][15:0])
            report_mismatch("first_rotated", m_axis_tdata[15:0], rotated_expected[0][15:0]);
          if (m_axis_tdata[31:16] !== rotated_expected[0][31:16])
            report_mismatch("second_rotated", m_axis_tdata[31:16], rotated_expected[0][31:16]);
          void'(rotated_expected.pop_front());
          pairs_checked++;
        end
      end
    end
  end

  task automatic add_pair(int x, int y, int pos, int idx);
    pair_req_t p;
    p.x = x[15:0];
    p.y = y[15:0];
    p.pos = pos[15:0];
    p.idx = idx[6:0];
    pending_reqs.push_back(p);
  endtask

  task automatic drain_pipe();
    while (pending_reqs.size() > 0 || rotated_expected.size() > 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t which, logic [23:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int hs_list[8] = '{0, 1, 2, 3, 256, 511, 64, 128};
    int lb_list[8] = '{870824, 0, 24'hFFFFFF, 870824, 870824, 24'h5A5A5A, 65536, 870824};
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    head_size_cfg = 9'd128;
    log2_base_cfg = 24'd870824;
    mismatches = 0;
    pairs_sent = 0;
    pairs_checked = 0;
    src_idle = 0;
    sink_idle = 0;
    quiet = 1'b0;
    req_taken = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // extremes, quadrants and saturating rotations under reset settings
    add_pair(32767, 32767, 0, 0);
    add_pair(-32768, -32768, 65535, 127);
    add_pair(-32768, 32767, 65535, 0);
    add_pair(32767, -32768, 1, 0);
    add_pair(-32768, -32768, 1, 0);
    add_pair(32767, 32767, 1, 0);
    add_pair(0, 0, 12345, 5);
    add_pair(1, -1, 2, 0);
    add_pair(-1, 1, 3, 0);
    add_pair(2048, 0, 4, 0);
    add_pair(0, 2048, 5, 0);
    add_pair(2048, 2048, 6, 0);
    add_pair(-2048, 2048, 65535, 1);
    add_pair(32767, 0, 65535, 63);
    add_pair(0, -32768, 65535, 64);
    add_pair(21845, -21846, 43690, 85);
    add_pair(-21846, 21845, 21845, 42);
    drain_pipe();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_HEAD_SIZE, 24'(hs_list[ph]));
      write_reg(REG_LOG2_BASE, 24'(lb_list[ph]));
      quiet = (ph == 7);
      for (int i = 0; i < 150; i++) begin
        case ($urandom_range(0, 3))
          0: add_pair($urandom, $urandom, $urandom_range(0, 15), $urandom_range(0, 127));
          1: add_pair($urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048,
                      $urandom, $urandom_range(0, 3));
          default: add_pair($urandom, $urandom, $urandom, $urandom_range(0, 127));
        endcase
      end
      drain_pipe();
    end

    $display("checked %0d of %0d rotated pairs over 9 head size and base settings,",
             pairs_checked, pairs_sent);
    $display("including extreme values, all quadrants and saturating rotations");
    if (mismatches == 0) begin
      $display("rotary_position_embedding_pair_unit verification clean");
    end else begin
      $display("rotary_position_embedding_pair_unit verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", rotated_expected.size());
    $display("rotary_position_embedding_pair_unit verification failed");
    $finish;
  end

endmodule
